[rtl/core/segment_intersection_test_top_defines.svh]
// ----------------------------------------------------------------------------
// Segment intersection test: assertion macros
// Concurrent assertion helpers on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_INTERSECTION_TEST_TOP_DEFINES_SVH
`define SEGMENT_INTERSECTION_TEST_TOP_DEFINES_SVH

// condition holds at every clock edge
`define SIT_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("segment intersection assertion failed");

// consequent holds in the cycle of the antecedent
`define SIT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("segment intersection assertion failed");

`endif

[rtl/core/sit_pkg.sv]
// ----------------------------------------------------------------------------
// Segment intersection test: package
// Widths, payload types and shared control structs.
// ----------------------------------------------------------------------------
package sit_pkg;

  localparam int unsigned CoordWidth = 16;
  localparam int unsigned DeltaWidth = CoordWidth + 1;
  localparam int unsigned ProdWidth  = 2 * CoordWidth + 2;
  localparam int unsigned LineWidth  = 2 * CoordWidth + 3;
  localparam int unsigned NumWidth   = 3 * CoordWidth + 6;
  localparam int unsigned DenWidth   = 2 * CoordWidth + 4;
  localparam int unsigned OutWidth   = 48;

  typedef logic signed [CoordWidth-1:0] coord_t;
  typedef logic signed [DeltaWidth-1:0] delta_t;

  typedef struct packed {
    coord_t a_x1;
    coord_t a_y1;
    coord_t a_x2;
    coord_t a_y2;
    coord_t b_x1;
    coord_t b_y1;
    coord_t b_x2;
    coord_t b_y2;
  } sit_in_t;

  typedef struct packed {
    logic                       hit;
    logic                       point_valid;
    logic signed [OutWidth-1:0] cross_x;
    logic signed [OutWidth-1:0] cross_y;
  } sit_out_t;

  typedef struct packed {
    coord_t ax_lo;
    coord_t ax_hi;
    coord_t ay_lo;
    coord_t ay_hi;
    coord_t bx_lo;
    coord_t bx_hi;
    coord_t by_lo;
    coord_t by_hi;
  } sit_bounds_t;

  // vld: stage holds an item; special: hit decided without box test
  typedef struct packed {
    logic vld;
    logic pv;
    logic hit;
    logic special;
  } sit_flags_t;

endpackage

[rtl/core/segment_intersection_test_top.sv]
// ----------------------------------------------------------------------------
// Segment intersection test: top level
// Classifies two segments, finds the crossing of their supporting lines in
// fixed point and tests it against both inclusive bounding boxes.
// ----------------------------------------------------------------------------
// One segment pair is taken every cycle while not held; its result passes
// through four stages of line setup, two of box test and divide setup, and
// a 49-stage divider (one stage per quotient bit of the 48-bit output plus
// sign and saturation). The whole pipeline advances together; it holds when
// the output register is full and not taken, and in_ready_o follows that.
`include "segment_intersection_test_top_defines.svh"

module segment_intersection_test_top import sit_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  sit_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output sit_out_t out_data_o
);

  localparam int unsigned MagWidth = NumWidth + FRAC_BITS;

  logic                       en;
  sit_flags_t                 front_flags, box_flags, x_sb, y_sb;
  logic signed [NumWidth-1:0] xn, yn;
  logic        [DenWidth-1:0] xd, yd, box_xd, box_yd;
  sit_bounds_t                bounds;
  logic        [MagWidth-1:0] xmag, ymag;
  logic                       xneg, yneg, xovf, yovf;
  logic signed [OutWidth-1:0] qx, qy;

  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  sit_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .vld_i    (in_valid_i),
    .in_i     (in_data_i),
    .flags_o  (front_flags),
    .xn_o     (xn),
    .yn_o     (yn),
    .xd_o     (xd),
    .yd_o     (yd),
    .bounds_o (bounds)
  );

  sit_box #(.FRAC_BITS(FRAC_BITS)) u_box (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .flags_i  (front_flags),
    .xn_i     (xn),
    .yn_i     (yn),
    .xd_i     (xd),
    .yd_i     (yd),
    .bounds_i (bounds),
    .flags_o  (box_flags),
    .xmag_o   (xmag),
    .ymag_o   (ymag),
    .xneg_o   (xneg),
    .yneg_o   (yneg),
    .xovf_o   (xovf),
    .yovf_o   (yovf),
    .xd_o     (box_xd),
    .yd_o     (box_yd)
  );

  sit_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .sb_i   (box_flags),
    .mag_i  (xmag),
    .den_i  (box_xd),
    .neg_i  (xneg),
    .ovf_i  (xovf),
    .sb_o   (x_sb),
    .q_o    (qx)
  );

  sit_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .sb_i   (box_flags),
    .mag_i  (ymag),
    .den_i  (box_yd),
    .neg_i  (yneg),
    .ovf_i  (yovf),
    .sb_o   (y_sb),
    .q_o    (qy)
  );

  assign out_valid_o             = x_sb.vld;
  assign out_data_o.hit          = x_sb.hit;
  assign out_data_o.point_valid  = x_sb.pv;
  assign out_data_o.cross_x      = qx;
  assign out_data_o.cross_y      = qy;

  `SIT_ASSERT_ALWAYS(div_lockstep_a, x_sb == y_sb)
  `SIT_ASSERT_IMP(hit_has_point_a, out_valid_o && out_data_o.hit, out_data_o.point_valid)
  `SIT_ASSERT_IMP(no_point_zero_a, out_valid_o && !out_data_o.point_valid, out_data_o.cross_x == '0 && out_data_o.cross_y == '0)

endmodule

[rtl/core/sit_front.sv]
// ----------------------------------------------------------------------------
// Segment intersection test: line setup
// Four stages: deltas, line constants, cross products, case selection with
// sign normalization of the crossing point fractions.
// ----------------------------------------------------------------------------
module sit_front import sit_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        vld_i,
  input  sit_in_t                     in_i,
  output sit_flags_t                  flags_o,
  output logic signed [NumWidth-1:0]  xn_o,
  output logic signed [NumWidth-1:0]  yn_o,
  output logic        [DenWidth-1:0]  xd_o,
  output logic        [DenWidth-1:0]  yd_o,
  output sit_bounds_t                 bounds_o
);

  // stage 1
  logic        vld1_q;
  sit_in_t     p1_q;
  sit_bounds_t bnd1_d, bnd1_q;
  delta_t      adx1_d, ady1_d, bdx1_d, bdy1_d;
  delta_t      adx1_q, ady1_q, bdx1_q, bdy1_q;

  always_comb begin
    adx1_d = DeltaWidth'(in_i.a_x2) - DeltaWidth'(in_i.a_x1);
    ady1_d = DeltaWidth'(in_i.a_y2) - DeltaWidth'(in_i.a_y1);
    bdx1_d = DeltaWidth'(in_i.b_x2) - DeltaWidth'(in_i.b_x1);
    bdy1_d = DeltaWidth'(in_i.b_y2) - DeltaWidth'(in_i.b_y1);
    bnd1_d.ax_lo = (in_i.a_x1 < in_i.a_x2) ? in_i.a_x1 : in_i.a_x2;
    bnd1_d.ax_hi = (in_i.a_x1 < in_i.a_x2) ? in_i.a_x2 : in_i.a_x1;
    bnd1_d.ay_lo = (in_i.a_y1 < in_i.a_y2) ? in_i.a_y1 : in_i.a_y2;
    bnd1_d.ay_hi = (in_i.a_y1 < in_i.a_y2) ? in_i.a_y2 : in_i.a_y1;
    bnd1_d.bx_lo = (in_i.b_x1 < in_i.b_x2) ? in_i.b_x1 : in_i.b_x2;
    bnd1_d.bx_hi = (in_i.b_x1 < in_i.b_x2) ? in_i.b_x2 : in_i.b_x1;
    bnd1_d.by_lo = (in_i.b_y1 < in_i.b_y2) ? in_i.b_y1 : in_i.b_y2;
    bnd1_d.by_hi = (in_i.b_y1 < in_i.b_y2) ? in_i.b_y2 : in_i.b_y1;
  end

  // stage 2
  logic                         vld2_q;
  sit_in_t                      p2_q;
  sit_bounds_t                  bnd2_q;
  delta_t                       adx2_q, ady2_q, bdx2_q, bdy2_q;
  logic signed [ProdWidth-1:0]  m_adx_ay, m_ady_ax, m_bdx_by, m_bdy_bx;
  logic signed [ProdWidth-1:0]  m_ady_bdx, m_bdy_adx;
  logic signed [ProdWidth-1:0]  m_bdy_ax, m_ady_bx, m_bdx_ay, m_adx_by;
  logic signed [ProdWidth-1:0]  m_bdy_ax2_q, m_ady_bx2_q, m_bdx_ay2_q, m_adx_by2_q;
  logic signed [LineWidth-1:0]  ac2_d, bc2_d, d2_d, ac2_q, bc2_q, d2_q;
  logic                         av2_d, ah2_d, bv2_d, bh2_d;
  logic                         av2_q, ah2_q, bv2_q, bh2_q;

  assign m_adx_ay  = ProdWidth'(adx1_q) * ProdWidth'(p1_q.a_y1);
  assign m_ady_ax  = ProdWidth'(ady1_q) * ProdWidth'(p1_q.a_x1);
  assign m_bdx_by  = ProdWidth'(bdx1_q) * ProdWidth'(p1_q.b_y1);
  assign m_bdy_bx  = ProdWidth'(bdy1_q) * ProdWidth'(p1_q.b_x1);
  assign m_ady_bdx = ProdWidth'(ady1_q) * ProdWidth'(bdx1_q);
  assign m_bdy_adx = ProdWidth'(bdy1_q) * ProdWidth'(adx1_q);
  assign m_bdy_ax  = ProdWidth'(bdy1_q) * ProdWidth'(p1_q.a_x1);
  assign m_ady_bx  = ProdWidth'(ady1_q) * ProdWidth'(p1_q.b_x1);
  assign m_bdx_ay  = ProdWidth'(bdx1_q) * ProdWidth'(p1_q.a_y1);
  assign m_adx_by  = ProdWidth'(adx1_q) * ProdWidth'(p1_q.b_y1);

  always_comb begin
    ac2_d = LineWidth'(m_adx_ay) - LineWidth'(m_ady_ax);
    bc2_d = LineWidth'(m_bdx_by) - LineWidth'(m_bdy_bx);
    d2_d  = LineWidth'(m_ady_bdx) - LineWidth'(m_bdy_adx);
    av2_d = (adx1_q == '0);
    ah2_d = !av2_d && (ady1_q == '0);
    bv2_d = (bdx1_q == '0);
    bh2_d = !bv2_d && (bdy1_q == '0);
  end

  // stage 3
  logic                         vld3_q;
  sit_in_t                      p3_q;
  sit_bounds_t                  bnd3_q;
  delta_t                       adx3_q, ady3_q, bdx3_q, bdy3_q;
  logic signed [LineWidth-1:0]  d3_q;
  logic                         av3_q, ah3_q, bv3_q, bh3_q;
  logic signed [NumWidth-1:0]   m_bc_adx, m_ac_bdx, m_bc_ady, m_ac_bdy;
  logic signed [NumWidth-1:0]   m_bc_adx3_q, m_ac_bdx3_q, m_bc_ady3_q, m_ac_bdy3_q;
  logic signed [NumWidth-1:0]   yn_av3_d, yn_bv3_d, xn_ah3_d, xn_bh3_d;
  logic signed [NumWidth-1:0]   yn_av3_q, yn_bv3_q, xn_ah3_q, xn_bh3_q;

  assign m_bc_adx = NumWidth'(bc2_q) * NumWidth'(adx2_q);
  assign m_ac_bdx = NumWidth'(ac2_q) * NumWidth'(bdx2_q);
  assign m_bc_ady = NumWidth'(bc2_q) * NumWidth'(ady2_q);
  assign m_ac_bdy = NumWidth'(ac2_q) * NumWidth'(bdy2_q);

  always_comb begin
    yn_av3_d = NumWidth'(m_bdy_ax2_q) + NumWidth'(bc2_q);
    yn_bv3_d = NumWidth'(m_ady_bx2_q) + NumWidth'(ac2_q);
    xn_ah3_d = NumWidth'(m_bdx_ay2_q) - NumWidth'(bc2_q);
    xn_bh3_d = NumWidth'(m_adx_by2_q) - NumWidth'(ac2_q);
  end

  // stage 4
  sit_flags_t                   f4_d, f4_q;
  logic signed [NumWidth-1:0]   xn4, yn4, xn4_d, yn4_d, xn4_q, yn4_q;
  logic signed [DenWidth-1:0]   xd4, yd4, xd4_d, yd4_d;
  logic        [DenWidth-1:0]   xd4_q, yd4_q;
  sit_bounds_t                  bnd4_q;

  always_comb begin
    f4_d.vld     = vld3_q;
    f4_d.special = 1'b1;
    f4_d.pv      = 1'b0;
    xn4 = NumWidth'(p3_q.a_x1);
    yn4 = NumWidth'(p3_q.a_y1);
    xd4 = DenWidth'(1);
    yd4 = DenWidth'(1);
    if (av3_q && bv3_q) begin
      f4_d.pv = (p3_q.a_x1 == p3_q.b_x1);
    end else if (ah3_q && bh3_q) begin
      f4_d.pv = (p3_q.a_y1 == p3_q.b_y1);
    end else if (!av3_q && !ah3_q && !bv3_q && !bh3_q && (d3_q == '0)) begin
      f4_d.pv = (m_bc_adx3_q == m_ac_bdx3_q);
    end else begin
      f4_d.special = 1'b0;
      f4_d.pv      = 1'b1;
      if (av3_q) begin
        if (!bh3_q) begin
          yn4 = yn_av3_q;
          yd4 = DenWidth'(bdx3_q);
        end else begin
          yn4 = NumWidth'(p3_q.b_y1);
        end
      end else if (bv3_q) begin
        xn4 = NumWidth'(p3_q.b_x1);
        if (!ah3_q) begin
          yn4 = yn_bv3_q;
          yd4 = DenWidth'(adx3_q);
        end
      end else if (ah3_q) begin
        xn4 = xn_ah3_q;
        xd4 = DenWidth'(bdy3_q);
      end else if (bh3_q) begin
        yn4 = NumWidth'(p3_q.b_y1);
        xn4 = xn_bh3_q;
        xd4 = DenWidth'(ady3_q);
      end else begin
        xn4 = m_bc_adx3_q - m_ac_bdx3_q;
        yn4 = m_bc_ady3_q - m_ac_bdy3_q;
        xd4 = DenWidth'(d3_q);
        yd4 = DenWidth'(d3_q);
      end
    end
    f4_d.hit = f4_d.pv;
    xn4_d = xd4[DenWidth-1] ? -xn4 : xn4;
    xd4_d = xd4[DenWidth-1] ? -xd4 : xd4;
    yn4_d = yd4[DenWidth-1] ? -yn4 : yn4;
    yd4_d = yd4[DenWidth-1] ? -yd4 : yd4;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
      f4_q   <= '0;
    end else if (en_i) begin
      vld1_q <= vld_i;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
      f4_q   <= f4_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p1_q   <= in_i;
      bnd1_q <= bnd1_d;
      adx1_q <= adx1_d;
      ady1_q <= ady1_d;
      bdx1_q <= bdx1_d;
      bdy1_q <= bdy1_d;

      p2_q        <= p1_q;
      bnd2_q      <= bnd1_q;
      adx2_q      <= adx1_q;
      ady2_q      <= ady1_q;
      bdx2_q      <= bdx1_q;
      bdy2_q      <= bdy1_q;
      ac2_q       <= ac2_d;
      bc2_q       <= bc2_d;
      d2_q        <= d2_d;
      m_bdy_ax2_q <= m_bdy_ax;
      m_ady_bx2_q <= m_ady_bx;
      m_bdx_ay2_q <= m_bdx_ay;
      m_adx_by2_q <= m_adx_by;
      av2_q       <= av2_d;
      ah2_q       <= ah2_d;
      bv2_q       <= bv2_d;
      bh2_q       <= bh2_d;

      p3_q        <= p2_q;
      bnd3_q      <= bnd2_q;
      adx3_q      <= adx2_q;
      ady3_q      <= ady2_q;
      bdx3_q      <= bdx2_q;
      bdy3_q      <= bdy2_q;
      d3_q        <= d2_q;
      av3_q       <= av2_q;
      ah3_q       <= ah2_q;
      bv3_q       <= bv2_q;
      bh3_q       <= bh2_q;
      m_bc_adx3_q <= m_bc_adx;
      m_ac_bdx3_q <= m_ac_bdx;
      m_bc_ady3_q <= m_bc_ady;
      m_ac_bdy3_q <= m_ac_bdy;
      yn_av3_q    <= yn_av3_d;
      yn_bv3_q    <= yn_bv3_d;
      xn_ah3_q    <= xn_ah3_d;
      xn_bh3_q    <= xn_bh3_d;

      xn4_q  <= xn4_d;
      yn4_q  <= yn4_d;
      xd4_q  <= unsigned'(xd4_d);
      yd4_q  <= unsigned'(yd4_d);
      bnd4_q <= bnd3_q;
    end
  end

  assign flags_o  = f4_q;
  assign xn_o     = xn4_q;
  assign yn_o     = yn4_q;
  assign xd_o     = xd4_q;
  assign yd_o     = yd4_q;
  assign bounds_o = bnd4_q;

endmodule

[rtl/core/sit_box.sv]
// ----------------------------------------------------------------------------
// Segment intersection test: bounding box test and divide setup
// Two stages: scaled box limits and magnitudes, then exact box compare and
// quotient overflow detection.
// ----------------------------------------------------------------------------
module sit_box import sit_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  sit_flags_t                            flags_i,
  input  logic signed [NumWidth-1:0]            xn_i,
  input  logic signed [NumWidth-1:0]            yn_i,
  input  logic        [DenWidth-1:0]            xd_i,
  input  logic        [DenWidth-1:0]            yd_i,
  input  sit_bounds_t                           bounds_i,
  output sit_flags_t                            flags_o,
  output logic        [NumWidth+FRAC_BITS-1:0]  xmag_o,
  output logic        [NumWidth+FRAC_BITS-1:0]  ymag_o,
  output logic                                  xneg_o,
  output logic                                  yneg_o,
  output logic                                  xovf_o,
  output logic                                  yovf_o,
  output logic        [DenWidth-1:0]            xd_o,
  output logic        [DenWidth-1:0]            yd_o
);

  localparam int unsigned MagWidth = NumWidth + FRAC_BITS;
  localparam int unsigned BoxWidth = NumWidth + 2;
  localparam int unsigned CmpWidth = (MagWidth > DenWidth + OutWidth) ?
                                     MagWidth : DenWidth + OutWidth;

  // stage 5
  logic signed [BoxWidth-1:0] xds, yds;
  logic signed [BoxWidth-1:0] lim_d [8];
  logic signed [BoxWidth-1:0] lim_q [8];
  logic        [NumWidth-1:0] xabs, yabs;
  logic        [MagWidth-1:0] xmag5_d, ymag5_d, xmag5_q, ymag5_q;
  logic                       xneg5_d, yneg5_d, xneg5_q, yneg5_q;
  logic        [DenWidth-1:0] xd5_d, yd5_d, xd5_q, yd5_q;
  logic signed [BoxWidth-1:0] xn5_q, yn5_q;
  sit_flags_t                 f5_q;

  always_comb begin
    xds = $signed(BoxWidth'(xd_i));
    yds = $signed(BoxWidth'(yd_i));
    lim_d[0] = BoxWidth'(bounds_i.ax_lo) * xds;
    lim_d[1] = BoxWidth'(bounds_i.ax_hi) * xds;
    lim_d[2] = BoxWidth'(bounds_i.ay_lo) * yds;
    lim_d[3] = BoxWidth'(bounds_i.ay_hi) * yds;
    lim_d[4] = BoxWidth'(bounds_i.bx_lo) * xds;
    lim_d[5] = BoxWidth'(bounds_i.bx_hi) * xds;
    lim_d[6] = BoxWidth'(bounds_i.by_lo) * yds;
    lim_d[7] = BoxWidth'(bounds_i.by_hi) * yds;
    xabs = xn_i[NumWidth-1] ? unsigned'(-xn_i) : unsigned'(xn_i);
    yabs = yn_i[NumWidth-1] ? unsigned'(-yn_i) : unsigned'(yn_i);
    if (flags_i.pv) begin
      xmag5_d = MagWidth'(xabs) << FRAC_BITS;
      ymag5_d = MagWidth'(yabs) << FRAC_BITS;
      xneg5_d = xn_i[NumWidth-1];
      yneg5_d = yn_i[NumWidth-1];
      xd5_d   = xd_i;
      yd5_d   = yd_i;
    end else begin
      xmag5_d = '0;
      ymag5_d = '0;
      xneg5_d = 1'b0;
      yneg5_d = 1'b0;
      xd5_d   = DenWidth'(1);
      yd5_d   = DenWidth'(1);
    end
  end

  // stage 6
  logic       in_a, in_b;
  sit_flags_t f6_d, f6_q;
  logic       xovf6_d, yovf6_d;

  always_comb begin
    in_a = (lim_q[0] <= xn5_q) && (xn5_q <= lim_q[1]) &&
           (lim_q[2] <= yn5_q) && (yn5_q <= lim_q[3]);
    in_b = (lim_q[4] <= xn5_q) && (xn5_q <= lim_q[5]) &&
           (lim_q[6] <= yn5_q) && (yn5_q <= lim_q[7]);
    f6_d = f5_q;
    if (!f5_q.special) begin
      f6_d.hit = f5_q.pv && in_a && in_b;
    end
    xovf6_d = CmpWidth'(xmag5_q) >= (CmpWidth'(xd5_q) << OutWidth);
    yovf6_d = CmpWidth'(ymag5_q) >= (CmpWidth'(yd5_q) << OutWidth);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f5_q <= '0;
      f6_q <= '0;
    end else if (en_i) begin
      f5_q <= flags_i;
      f6_q <= f6_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lim_q   <= lim_d;
      xn5_q   <= BoxWidth'(xn_i);
      yn5_q   <= BoxWidth'(yn_i);
      xmag5_q <= xmag5_d;
      ymag5_q <= ymag5_d;
      xneg5_q <= xneg5_d;
      yneg5_q <= yneg5_d;
      xd5_q   <= xd5_d;
      yd5_q   <= yd5_d;

      xmag_o <= xmag5_q;
      ymag_o <= ymag5_q;
      xneg_o <= xneg5_q;
      yneg_o <= yneg5_q;
      xd_o   <= xd5_q;
      yd_o   <= yd5_q;
      xovf_o <= xovf6_d;
      yovf_o <= yovf6_d;
    end
  end

  assign flags_o = f6_q;

endmodule

[rtl/core/sit_div.sv]
// ----------------------------------------------------------------------------
// Segment intersection test: pipelined divider
// Restoring division, one quotient bit per stage, then sign and saturation.
// ----------------------------------------------------------------------------
module sit_div import sit_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  sit_flags_t                            sb_i,
  input  logic        [NumWidth+FRAC_BITS-1:0]  mag_i,
  input  logic        [DenWidth-1:0]            den_i,
  input  logic                                  neg_i,
  input  logic                                  ovf_i,
  output sit_flags_t                            sb_o,
  output logic signed [OutWidth-1:0]            q_o
);

  localparam int unsigned MagWidth = NumWidth + FRAC_BITS;
  localparam int unsigned RemWidth = (MagWidth > DenWidth + OutWidth) ?
                                     MagWidth : DenWidth + OutWidth;
  localparam logic [OutWidth-1:0] MaxPos = {1'b0, {(OutWidth-1){1'b1}}};
  localparam logic [OutWidth-1:0] MinNeg = {1'b1, {(OutWidth-1){1'b0}}};

  logic [RemWidth-1:0] rem_q [OutWidth];
  logic [OutWidth-1:0] quo_q [OutWidth];
  logic [DenWidth-1:0] den_q [OutWidth];
  logic                neg_q [OutWidth];
  logic                ovf_q [OutWidth];
  sit_flags_t          sb_q  [OutWidth];

  for (genvar k = 0; k < OutWidth; k++) begin : g_step
    localparam int unsigned Bit = OutWidth - 1 - k;
    logic [RemWidth-1:0] rem_in, trial;
    logic [OutWidth-1:0] quo_in;
    logic [DenWidth-1:0] den_in;
    logic                neg_in, ovf_in;
    sit_flags_t          sb_in;

    if (k == 0) begin : g_first
      assign rem_in = RemWidth'(mag_i);
      assign quo_in = '0;
      assign den_in = den_i;
      assign neg_in = neg_i;
      assign ovf_in = ovf_i;
      assign sb_in  = sb_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign quo_in = quo_q[k-1];
      assign den_in = den_q[k-1];
      assign neg_in = neg_q[k-1];
      assign ovf_in = ovf_q[k-1];
      assign sb_in  = sb_q[k-1];
    end

    assign trial = RemWidth'(den_in) << Bit;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sb_q[k] <= '0;
      end else if (en_i) begin
        sb_q[k] <= sb_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (rem_in >= trial) begin
          rem_q[k] <= rem_in - trial;
          quo_q[k] <= quo_in | (OutWidth'(1) << Bit);
        end else begin
          rem_q[k] <= rem_in;
          quo_q[k] <= quo_in;
        end
        den_q[k] <= den_in;
        neg_q[k] <= neg_in;
        ovf_q[k] <= ovf_in;
      end
    end
  end

  logic [OutWidth-1:0] quo_last, res_d;
  logic [OutWidth-1:0] res_q;
  sit_flags_t          sb_last_q;

  assign quo_last = quo_q[OutWidth-1];

  always_comb begin
    if (ovf_q[OutWidth-1]) begin
      res_d = neg_q[OutWidth-1] ? MinNeg : MaxPos;
    end else if (!neg_q[OutWidth-1]) begin
      res_d = quo_last[OutWidth-1] ? MaxPos : quo_last;
    end else begin
      res_d = (quo_last > MinNeg) ? MinNeg : -quo_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sb_last_q <= '0;
    end else if (en_i) begin
      sb_last_q <= sb_q[OutWidth-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign sb_o = sb_last_q;
  assign q_o  = signed'(res_q);

endmodule

[test/tb_segment_intersection_test_top.sv]
// ----------------------------------------------------------------------------
// Segment intersection test: testbench
// Drives segment pairs over the valid/ready input with random gaps. Each
// accepted pair has a preset or exact wide-integer predicted result. Outputs
// are checked field by field against the oldest expected result.
// ----------------------------------------------------------------------------
module tb_segment_intersection_test_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sit_pkg::*;

  localparam int unsigned FracBits   = 16;
  localparam int unsigned NumItems   = 1800;
  localparam int unsigned Settle     = 70;
  localparam int unsigned CycleLimit = 200000;

  typedef logic signed [191:0] wide_t;
  typedef enum logic [1:0] {KindVert, KindHoriz, KindSloped} seg_kind_e;

  typedef struct {
    longint    x1, y1, x2, y2, dx, dy;
    wide_t     c;
    seg_kind_e kind;
  } seg_t;

  typedef struct {
    sit_in_t  pair;
    bit       typed;
    sit_out_t res;
  } row_t;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_ready_o;
  sit_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_ready_i;
  sit_out_t out_data_o;

  sit_out_t    expected_q[$];
  row_t        rows[$];
  int unsigned mismatches;
  int unsigned cycles;
  bit          quiet;

  segment_intersection_test_top #(
    .FRAC_BITS(FracBits)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic seg_t build_seg(coord_t x1, coord_t y1, coord_t x2, coord_t y2);
    seg_t s;
    s.x1 = longint'(x1); s.y1 = longint'(y1); s.x2 = longint'(x2); s.y2 = longint'(y2);
    s.dx = s.x2 - s.x1;
    s.dy = s.y2 - s.y1;
    s.kind = (s.dx == 0) ? KindVert : ((s.dy == 0) ? KindHoriz : KindSloped);
    s.c = wide_t'(s.dx) * wide_t'(s.y1) - wide_t'(s.dy) * wide_t'(s.x1);
    return s;
  endfunction

  function automatic bit within_span(wide_t num, wide_t den, longint a, longint b);
    wide_t lo, hi;
    lo = wide_t'((a < b) ? a : b);
    hi = wide_t'((a < b) ? b : a);
    return (lo * den <= num) && (num <= hi * den);
  endfunction

  function automatic bit within_box(seg_t s, wide_t xn, wide_t xd, wide_t yn, wide_t yd);
    return within_span(xn, xd, s.x1, s.x2) && within_span(yn, yd, s.y1, s.y2);
  endfunction

  function automatic logic [47:0] to_fixed(wide_t n, wide_t d);
    wide_t q, hi, lo;
    hi = (wide_t'(1) <<< 47) - wide_t'(1);
    lo = -(wide_t'(1) <<< 47);
    q = (n <<< FracBits) / d;
    if (q > hi) q = hi;
    if (q < lo) q = lo;
    return q[47:0];
  endfunction

  function automatic sit_out_t crossing(sit_in_t p);
    seg_t     a, b;
    wide_t    xn, xd, yn, yd, den;
    bit       hit, valid;
    sit_out_t r;
    a = build_seg(p.a_x1, p.a_y1, p.a_x2, p.a_y2);
    b = build_seg(p.b_x1, p.b_y1, p.b_x2, p.b_y2);
    xn = wide_t'(a.x1); yn = wide_t'(a.y1); xd = wide_t'(1); yd = wide_t'(1);
    hit = 1'b0; valid = 1'b0;
    if (a.kind == KindVert && b.kind == KindVert) begin
      valid = (a.x1 == b.x1);
      hit = valid;
    end else if (a.kind == KindHoriz && b.kind == KindHoriz) begin
      valid = (a.y1 == b.y1);
      hit = valid;
    end else if (a.kind == KindSloped && b.kind == KindSloped &&
                 a.dy * b.dx == b.dy * a.dx) begin
      valid = (a.c * wide_t'(b.dx) == b.c * wide_t'(a.dx));
      hit = valid;
    end else begin
      valid = 1'b1;
      if (a.kind == KindVert) begin
        xn = wide_t'(a.x1);
        if (b.kind == KindHoriz) begin
          yn = wide_t'(b.y1);
        end else begin
          yn = wide_t'(b.dy) * wide_t'(a.x1) + b.c; yd = wide_t'(b.dx);
        end
      end else if (b.kind == KindVert) begin
        xn = wide_t'(b.x1);
        if (a.kind == KindHoriz) begin
          yn = wide_t'(a.y1);
        end else begin
          yn = wide_t'(a.dy) * wide_t'(b.x1) + a.c; yd = wide_t'(a.dx);
        end
      end else if (a.kind == KindHoriz) begin
        yn = wide_t'(a.y1);
        xn = wide_t'(b.dx) * wide_t'(a.y1) - b.c; xd = wide_t'(b.dy);
      end else if (b.kind == KindHoriz) begin
        yn = wide_t'(b.y1);
        xn = wide_t'(a.dx) * wide_t'(b.y1) - a.c; xd = wide_t'(a.dy);
      end else begin
        den = wide_t'(a.dy) * wide_t'(b.dx) - wide_t'(b.dy) * wide_t'(a.dx);
        xn = b.c * wide_t'(a.dx) - a.c * wide_t'(b.dx);
        yn = b.c * wide_t'(a.dy) - a.c * wide_t'(b.dy);
        xd = den; yd = den;
      end
      if (xd < 0) begin xd = -xd; xn = -xn; end
      if (yd < 0) begin yd = -yd; yn = -yn; end
      hit = within_box(a, xn, xd, yn, yd) && within_box(b, xn, xd, yn, yd);
    end
    r.hit = hit;
    r.point_valid = valid;
    r.cross_x = valid ? to_fixed(xn, xd) : '0;
    r.cross_y = valid ? to_fixed(yn, yd) : '0;
    return r;
  endfunction

  function automatic sit_in_t pack_pair(int ax1, int ay1, int ax2, int ay2,
                                        int bx1, int by1, int bx2, int by2);
    sit_in_t p;
    p.a_x1 = coord_t'(ax1); p.a_y1 = coord_t'(ay1);
    p.a_x2 = coord_t'(ax2); p.a_y2 = coord_t'(ay2);
    p.b_x1 = coord_t'(bx1); p.b_y1 = coord_t'(by1);
    p.b_x2 = coord_t'(bx2); p.b_y2 = coord_t'(by2);
    return p;
  endfunction

  function automatic void add_row(sit_in_t p, bit typed, sit_out_t r);
    row_t w;
    w.pair = p; w.typed = typed; w.res = r;
    rows.push_back(w);
  endfunction

  function automatic int srand(int span);
    return int'($urandom_range(2 * span)) - span;
  endfunction

  function automatic sit_in_t random_pair();
    sit_in_t p;
    int cx, cy, dx, dy, ex, ey, t1, t2, t3, t4, off;
    case ($urandom_range(6))
      0: p = sit_in_t'({$urandom, $urandom, $urandom, $urandom});
      1: p = pack_pair(srand(6), srand(6), srand(6), srand(6),
                       srand(6), srand(6), srand(6), srand(6));
      2: begin
        cx = srand(2000); cy = srand(2000);
        p = pack_pair(cx, srand(3000), cx, srand(3000),
                      srand(3000), cy, srand(3000), cy);
        if ($urandom_range(1)) p = pack_pair(p.a_x1, p.a_y1, p.a_x2, p.a_y2,
                                             srand(3000), srand(3000),
                                             srand(3000), srand(3000));
        if ($urandom_range(1)) p = {p[63:0], p[127:64]};
      end
      3, 4: begin
        cx = srand(1000); cy = srand(1000);
        dx = srand(20); dy = srand(20);
        t1 = srand(20); t2 = srand(20); t3 = srand(20); t4 = srand(20);
        off = ($urandom_range(3) == 0) ? 0 : srand(5);
        p = pack_pair(cx + t1 * dx, cy + t1 * dy, cx + t2 * dx, cy + t2 * dy,
                      cx + t3 * dx, cy + t3 * dy + off, cx + t4 * dx, cy + t4 * dy + off);
      end
      5: begin
        cx = srand(30000); cy = srand(30000);
        dx = srand(2700); dy = srand(2700); ex = srand(2700); ey = srand(2700);
        p = pack_pair(cx - dx, cy - dy, cx + dx + srand(2), cy + dy,
                      cx - ex, cy - ey + srand(2), cx + ex, cy + ey);
      end
      default: begin
        dx = srand(32767); dy = srand(32767);
        p = pack_pair(-dx, -dy, dx, dy, -dx + srand(3), -dy + srand(3),
                      dx + srand(3), dy + srand(3));
      end
    endcase
    return p;
  endfunction

  function automatic void report(string field, logic [47:0] exp_v, logic [47:0] act_v);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s: expected %h, got %h", field, exp_v, act_v);
  endfunction

  // input side
  initial begin
    sit_in_t  p;
    sit_out_t r;
    sit_out_t z;
    int unsigned n;
    z = '0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    quiet = 1'b0;
    mismatches = 0;

    add_row(pack_pair(0, 0, 0, 0, 0, 0, 0, 0), 1'b1, '{1'b1, 1'b1, 48'h0, 48'h0});
    add_row(pack_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768), 1'b1,
            '{1'b1, 1'b1, 48'hFFFF_FFFF_8000, 48'hFFFF_FFFF_8000});
    add_row(pack_pair(0, 0, 1, 1, 0, 1, 1, 2), 1'b1, z);
    add_row(pack_pair(5, 0, 5, 9, 6, 0, 6, 9), 1'b1, z);
    add_row(pack_pair(5, 0, 5, 1, 5, 100, 5, 200), 1'b1, '{1'b1, 1'b1, 48'h5_0000, 48'h0});
    add_row(pack_pair(-32768, 32767, -32767, 32767, 32766, 32767, 32767, 32767), 1'b1,
            '{1'b1, 1'b1, 48'hFFFF_8000_0000, 48'h0000_7FFF_0000});
    add_row(pack_pair(0, 3, 9, 3, 0, 4, 9, 4), 1'b1, z);
    add_row(pack_pair(0, 0, 2, 4, 10, 20, 11, 22), 1'b1, '{1'b1, 1'b1, 48'h0, 48'h0});
    add_row(pack_pair(3, -5, 3, 5, -4, 2, 9, 2), 1'b1,
            '{1'b1, 1'b1, 48'h3_0000, 48'h2_0000});
    add_row(pack_pair(3, -5, 3, 5, 4, 2, 9, 2), 1'b1,
            '{1'b0, 1'b1, 48'h3_0000, 48'h2_0000});
    add_row(pack_pair(7, 7, 7, 7, 7, -3, 7, -3), 1'b1,
            '{1'b1, 1'b1, 48'h7_0000, 48'h7_0000});
    add_row(pack_pair(1, 1, 1, 1, 0, 0, 2, 2), 1'b0, z);
    add_row(pack_pair(-32768, -32768, 32767, 32766, -32768, -32767, 32767, 32767), 1'b0, z);
    add_row(pack_pair(-32768, 32767, 32767, -32768, -32767, 32767, 32767, -32767), 1'b0, z);
    add_row(pack_pair(0, 1, 3, 1, 0, 0, 7, 3), 1'b0, z);
    add_row(pack_pair(0, 0, 7, 3, 2, -9, 2, 9), 1'b0, z);
    add_row(pack_pair(0, 0, 3, 7, 1, 0, 4, 5), 1'b0, z);
    add_row(pack_pair(32767, -32768, -32768, 32767, 0, 0, 1, 0), 1'b0, z);
    add_row(pack_pair(-1, -1, -1, -1, -1, -1, -1, -1), 1'b0, z);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (n = 0; n < rows.size() + NumItems; n++) begin
      quiet = (n >= 600 && n < 1000);
      if (n < rows.size()) begin
        p = rows[n].pair;
        r = rows[n].typed ? rows[n].res : crossing(p);
      end else begin
        p = random_pair();
        r = crossing(p);
      end
      if (!quiet && $urandom_range(99) < 9) begin
        in_valid_i <= 1'b0;
        do @(posedge clk_i); while ($urandom_range(99) < 40);
      end
      in_valid_i <= 1'b1;
      in_data_i <= p;
      forever begin
        @(posedge clk_i);
        if (in_ready_o) break;
      end
      expected_q.push_back(r);
    end
    in_valid_i <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (Settle) @(posedge clk_i);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("tb_segment_intersection_test_top passed");
    end else begin
      $display("tb_segment_intersection_test_top failed");
    end
    $finish;
  end

  // output side
  initial begin
    sit_out_t e;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        if (expected_q.size() == 0) begin
          report("unexpected transfer", '0, out_data_o.cross_x);
        end else begin
          e = expected_q.pop_front();
          if (out_data_o.hit !== e.hit) report("hit", 48'(e.hit), 48'(out_data_o.hit));
          if (out_data_o.point_valid !== e.point_valid)
            report("point_valid", 48'(e.point_valid), 48'(out_data_o.point_valid));
          if (out_data_o.cross_x !== e.cross_x) report("cross_x", e.cross_x, out_data_o.cross_x);
          if (out_data_o.cross_y !== e.cross_y) report("cross_y", e.cross_y, out_data_o.cross_y);
        end
      end
      out_ready_i <= quiet || ($urandom_range(99) >= 9);
    end
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("tb_segment_intersection_test_top failed");
        $finish;
      end
    end
  end

endmodule
